// ----- rtl/core/four_wheel_drive_command_controller_core_assert.svh -----
// Assertion macros shared by the four-wheel drive controller core.
`ifndef FOUR_WHEEL_DRIVE_COMMAND_CONTROLLER_CORE_ASSERT_SVH
`define FOUR_WHEEL_DRIVE_COMMAND_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FWDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fwdc_pkg.sv -----
// Shared types and constants of the four-wheel drive controller core.
package fwdc_pkg;

  localparam int NUM_WHEELS = 4;

  // wheel index and last-wheel code
  localparam logic [1:0] LAST_WHEEL = 2'd3;

  // command codes
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_VELOCITY  = 2'd1;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd2;
  localparam logic [1:0] CMD_OTHER     = 2'd3;

  // drive direction codes
  localparam logic [1:0] DIR_OFF     = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HB_TIMEOUT    = 2'd0;
  localparam logic [1:0] CFG_CTRL_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_WIDE_MASK     = 2'd2;

  // configuration reset values
  localparam logic [15:0] HB_TIMEOUT_RST    = 16'd200;
  localparam logic [15:0] CTRL_INTERVAL_RST = 16'd20;
  localparam logic [3:0]  WIDE_MASK_RST     = 4'd9;

  // open-loop drive scaling: duty = |target| * 4999 / 300, clamped
  localparam logic [12:0] DUTY_MAX   = 13'd4999;
  localparam logic [15:0] SPEED_FULL = 16'd300;
  // ceil(4999 * 2^17 / 300); exact floor for |target| below 300
  localparam logic [21:0] DUTY_RECIP = 22'd2184097;
  localparam int          DUTY_SHIFT = 17;

  typedef logic signed [NUM_WHEELS-1:0][15:0] rpm_arr_t;
  typedef logic [NUM_WHEELS-1:0][31:0]        count_arr_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    rpm_arr_t    rpm;
    count_arr_t  count;
  } step_t;

  typedef struct packed {
    logic load_target;
    logic alive;
    logic control;
  } wheel_ctl_t;

  typedef struct packed {
    logic [1:0]         dir;
    logic [12:0]        duty;
    logic signed [31:0] ticks;
  } wheel_res_t;

  typedef wheel_res_t [NUM_WHEELS-1:0] wheel_res_arr_t;

endpackage

// ----- rtl/core/fwdc_step_if.sv -----
// Input channel: one control-loop pass per item.
interface fwdc_step_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        now_ms;
  logic signed [15:0] rpm_front_left;
  logic signed [15:0] rpm_front_right;
  logic signed [15:0] rpm_rear_left;
  logic signed [15:0] rpm_rear_right;
  logic [31:0]        count_front_left;
  logic [31:0]        count_front_right;
  logic [31:0]        count_rear_left;
  logic [31:0]        count_rear_right;

  modport source (
    output valid, cmd, now_ms,
    output rpm_front_left, rpm_front_right, rpm_rear_left, rpm_rear_right,
    output count_front_left, count_front_right, count_rear_left, count_rear_right,
    input  ready
  );

  modport sink (
    input  valid, cmd, now_ms,
    input  rpm_front_left, rpm_front_right, rpm_rear_left, rpm_rear_right,
    input  count_front_left, count_front_right, count_rear_left, count_rear_right,
    output ready
  );
endinterface

// ----- rtl/core/fwdc_result_if.sv -----
// Output channel: one per-wheel drive and encoder report per item.
interface fwdc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_index;
  logic [1:0]         drive_dir;
  logic [12:0]        duty;
  logic signed [31:0] cumulative_ticks;
  logic               report;
  logic               last_motor;

  modport source (
    output valid, motor_index, drive_dir, duty, cumulative_ticks, report, last_motor,
    input  ready
  );

  modport sink (
    input  valid, motor_index, drive_dir, duty, cumulative_ticks, report, last_motor,
    output ready
  );
endinterface

// ----- rtl/core/fwdc_sched.sv -----
// Heartbeat watchdog and control-interval timer.
module fwdc_sched
  import fwdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic [15:0] hb_timeout,
  input  logic [15:0] ctrl_interval,
  output wheel_ctl_t  ctl
);

  logic [31:0] last_hb;
  logic [31:0] last_ctrl;
  logic [31:0] hb_ref;
  logic        is_heartbeat;

  // a heartbeat on this item re-arms the watchdog before the check
  assign is_heartbeat = (cmd == CMD_HEARTBEAT);
  assign hb_ref       = is_heartbeat ? now_ms : last_hb;

  assign ctl.load_target = (cmd == CMD_VELOCITY);
  assign ctl.alive       = (now_ms - hb_ref) <= {16'd0, hb_timeout};
  assign ctl.control     = (now_ms - last_ctrl) >= {16'd0, ctrl_interval};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_hb   <= '0;
      last_ctrl <= '0;
    end else if (upd) begin
      if (is_heartbeat) begin
        last_hb <= now_ms;
      end
      if (ctl.control) begin
        last_ctrl <= now_ms;
      end
    end
  end

`include "four_wheel_drive_command_controller_core_assert.svh"

  `FWDC_ASSERT_SAME(a_hb_keeps_alive, upd && is_heartbeat, ctl.alive, "heartbeat item expired")
  `FWDC_ASSERT_NEXT(a_hb_recorded, upd && is_heartbeat, last_hb == $past(now_ms), "heartbeat time not held")

endmodule

// ----- rtl/core/fwdc_wheel.sv -----
// Per-wheel target, open-loop drive and encoder extension.
module fwdc_wheel
  import fwdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               upd,
  input  wheel_ctl_t         ctl,
  input  logic               wide,
  input  logic signed [15:0] rpm,
  input  logic [31:0]        sample,
  output wheel_res_t         res
);

  logic signed [15:0] target;
  logic signed [15:0] target_next;
  logic [31:0]        tick;
  logic [15:0]        prev;
  logic [12:0]        duty;
  logic [1:0]         dir;

  logic [15:0] mag;
  logic [30:0] prod;
  logic [12:0] duty_calc;
  logic [1:0]  dir_calc;
  logic [15:0] diff;
  logic [31:0] tick_next;

  always_comb begin
    target_next = ctl.load_target ? rpm : target;
    if (!ctl.alive) begin
      target_next = '0;
    end
  end

  // scale |target| below full speed by a reciprocal multiply, clamp above
  assign mag  = target_next[15] ? 16'(-target_next) : 16'(target_next);
  assign prod = 31'(mag[8:0]) * 31'(DUTY_RECIP);

  always_comb begin
    if (mag >= SPEED_FULL) begin
      duty_calc = DUTY_MAX;
    end else begin
      duty_calc = 13'(prod >> DUTY_SHIFT);
    end
    if (duty_calc == '0) begin
      dir_calc = DIR_OFF;
    end else if (target_next[15]) begin
      dir_calc = DIR_REVERSE;
    end else begin
      dir_calc = DIR_FORWARD;
    end
  end

  // narrow counter: add the signed 16-bit step since the last sample
  assign diff = sample[15:0] - prev;
  assign tick_next = wide ? sample : tick + {{16{diff[15]}}, diff};

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      tick   <= '0;
      prev   <= '0;
      duty   <= '0;
      dir    <= DIR_OFF;
    end else if (upd) begin
      target <= target_next;
      if (!ctl.alive) begin
        duty <= '0;
        dir  <= DIR_OFF;
      end else if (ctl.control) begin
        duty <= duty_calc;
        dir  <= dir_calc;
      end
      if (ctl.control) begin
        tick <= tick_next;
        if (!wide) begin
          prev <= sample[15:0];
        end
      end
    end
  end

  assign res.dir   = dir;
  assign res.duty  = duty;
  assign res.ticks = tick;

endmodule

// ----- rtl/core/fwdc_out.sv -----
// Result stage: sends the four wheel reports of an item in order.
module fwdc_out
  import fwdc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            report_in,
  input  wheel_res_arr_t  res,
  output logic            free,
  fwdc_result_if.source   result
);

  logic       res_valid;
  logic [1:0] idx;
  logic       report;
  logic       fire;
  logic       last;

  assign fire = result.valid && result.ready;
  assign last = (idx == LAST_WHEEL);
  assign free = !res_valid || (fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (last) begin
        res_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report <= report_in;
    end
  end

  assign result.valid            = res_valid;
  assign result.motor_index      = idx;
  assign result.drive_dir        = res[idx].dir;
  assign result.duty             = res[idx].duty;
  assign result.cumulative_ticks = res[idx].ticks;
  assign result.report           = report;
  assign result.last_motor       = last;

`include "four_wheel_drive_command_controller_core_assert.svh"

  `FWDC_ASSERT_NEXT(a_load_starts, load, res_valid && idx == '0, "load did not restart at wheel 0")
  `FWDC_ASSERT_NEXT(a_idx_steps, fire && !last, res_valid && idx == $past(idx) + 2'd1, "wheel skipped")
  `FWDC_ASSERT_NEXT(a_stall_holds, res_valid && !result.ready, res_valid && $stable(idx), "stalled report moved")

endmodule

// ----- rtl/core/four_wheel_drive_command_controller_core.sv -----
// Top level of the four-wheel drive command controller core.
//
// Each item on the step channel is one pass of the motor control loop: the
// millisecond time, at most one received command (a velocity set for all
// four wheels, or a heartbeat) and four raw encoder samples. The core keeps
// the wheel targets, a heartbeat watchdog that stops every drive once more
// than the heartbeat timeout has gone by without a heartbeat, and a control
// timer.
// On a control step (control_interval_ms elapsed) it extends the encoder
// counters to 32-bit tick totals and sets each open-loop drive from its
// target: direction from the sign, duty = |target| * 4999 / 300 truncated
// and clamped to 4999. Every item yields four results on the result
// channel, wheels 0 to 3 in order, last_motor marking the fourth; report is
// set when the item was a control step. An accepted item waits in the input
// register until the result stage is free, then updates all state and
// loads the result stage in the same cycle. The four reports leave one per
// cycle while the receiver holds ready, and the input register takes the
// next item while reports are still draining. Configuration is written
// through cfg_we/cfg_index/cfg_data (0 heartbeat timeout, 1 control
// interval, 2 wide counter mask; index 3 is ignored) and takes effect on
// the next item; write it only while the core is idle.
module four_wheel_drive_command_controller_core
  import fwdc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fwdc_step_if.sink     step,
  fwdc_result_if.source result,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  // configuration registers
  logic [15:0] hb_timeout;
  logic [15:0] ctrl_interval;
  logic [3:0]  wide_mask;

  // input register
  logic  step_valid;
  step_t step_q;

  logic           advance;
  logic           out_free;
  wheel_ctl_t     ctl;
  wheel_res_arr_t wheel_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_timeout    <= HB_TIMEOUT_RST;
      ctrl_interval <= CTRL_INTERVAL_RST;
      wide_mask     <= WIDE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HB_TIMEOUT:    hb_timeout    <= cfg_data;
        CFG_CTRL_INTERVAL: ctrl_interval <= cfg_data;
        CFG_WIDE_MASK:     wide_mask     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // move the held item into the state update once the result stage is free
  assign advance    = step_valid && out_free;
  assign step.ready = !step_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (step.ready) begin
      step_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      step_q.cmd      <= step.cmd;
      step_q.now_ms   <= step.now_ms;
      step_q.rpm[0]   <= step.rpm_front_left;
      step_q.rpm[1]   <= step.rpm_front_right;
      step_q.rpm[2]   <= step.rpm_rear_left;
      step_q.rpm[3]   <= step.rpm_rear_right;
      step_q.count[0] <= step.count_front_left;
      step_q.count[1] <= step.count_front_right;
      step_q.count[2] <= step.count_rear_left;
      step_q.count[3] <= step.count_rear_right;
    end
  end

  // watchdog and control timer decide what this pass does
  fwdc_sched u_sched (
    .clk           (clk),
    .rst           (rst),
    .upd           (advance),
    .cmd           (step_q.cmd),
    .now_ms        (step_q.now_ms),
    .hb_timeout    (hb_timeout),
    .ctrl_interval (ctrl_interval),
    .ctl           (ctl)
  );

  // one lane per wheel; each lane's held state is what gets reported
  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
    fwdc_wheel u_wheel (
      .clk    (clk),
      .rst    (rst),
      .upd    (advance),
      .ctl    (ctl),
      .wide   (wide_mask[w]),
      .rpm    (step_q.rpm[w]),
      .sample (step_q.count[w]),
      .res    (wheel_res[w])
    );
  end

  // serialize the four wheel reports
  fwdc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .report_in (ctl.control),
    .res       (wheel_res),
    .free      (out_free),
    .result    (result)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the four-wheel drive command controller core.
module tb;
  import fwdc_pkg::*;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to hold after the last report so the core is idle again.
  localparam int HOLD_OFF = 8;
  // Register index with no register behind it; writes to it must be dropped.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  motor_index;
    logic [1:0]  dir;
    logic [12:0] duty;
    logic [31:0] ticks;
    logic        report;
    logic        last_motor;
  } wheel_report_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fwdc_step_if   step_ch ();
  fwdc_result_if result_ch ();

  four_wheel_drive_command_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .step      (step_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Drive model: configuration and loop state, mirrored from the core.
  logic [15:0]        hb_timeout_cfg;
  logic [15:0]        interval_cfg;
  logic [3:0]         wide_mask_cfg;
  logic signed [15:0] model_target [NUM_WHEELS];
  logic [31:0]        last_hb_ms;
  logic [31:0]        last_ctl_ms;
  logic [31:0]        tick_total [NUM_WHEELS];
  logic [15:0]        prev_count [NUM_WHEELS];
  logic [12:0]        held_duty [NUM_WHEELS];
  logic [1:0]         held_dir [NUM_WHEELS];

  // Per-wheel reports still owed by the core, oldest first.
  wheel_report_t wheel_reports_due [$];

  int         error_count = 0;
  int         stall_cycles = 0;
  bit         bursts_on = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  count_arr_t enc_count = '0;

  // 20-unit clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    begin
      error_count++;
      if (error_count <= 50) $display("ERROR %0t: %s", $time, msg);
    end
  endtask

  // Load the reset values of every register and state element.
  task automatic reset_model;
    begin
      hb_timeout_cfg = HB_TIMEOUT_RST;
      interval_cfg   = CTRL_INTERVAL_RST;
      wide_mask_cfg  = WIDE_MASK_RST;
      last_hb_ms     = '0;
      last_ctl_ms    = '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        model_target[i] = '0;
        tick_total[i] = '0;
        prev_count[i] = '0;
        held_duty[i]  = '0;
        held_dir[i]   = DIR_OFF;
      end
    end
  endtask

  // Advance the drive model by one loop pass and queue the four reports it owes.
  task automatic drive_model_step(input step_t s);
    logic [31:0]        since_hb;
    logic [31:0]        since_ctl;
    logic [31:0]        mag;
    logic [31:0]        scaled;
    logic [15:0]        narrow;
    logic [15:0]        diff;
    logic signed [31:0] t32;
    logic               alive;
    logic               control;
    wheel_report_t      r;
    begin
      // Take the command first, so a heartbeat re-arms before the expiry check.
      if (s.cmd == CMD_VELOCITY) begin
        for (int i = 0; i < NUM_WHEELS; i++) model_target[i] = s.rpm[i];
      end else if (s.cmd == CMD_HEARTBEAT) begin
        last_hb_ms = s.now_ms;
      end

      // Expired watchdog: drop targets and stop every drive on this pass.
      since_hb = s.now_ms - last_hb_ms;
      alive = since_hb <= {16'd0, hb_timeout_cfg};
      if (!alive) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          model_target[i] = '0;
          held_duty[i]  = '0;
          held_dir[i]   = DIR_OFF;
        end
      end

      since_ctl = s.now_ms - last_ctl_ms;
      control = since_ctl >= {16'd0, interval_cfg};
      if (control) begin
        last_ctl_ms = s.now_ms;
        for (int i = 0; i < NUM_WHEELS; i++) begin
          // Wide counter: take as is. Narrow: add the signed 16-bit delta.
          if (wide_mask_cfg[i]) begin
            tick_total[i] = s.count[i];
          end else begin
            narrow = s.count[i][15:0];
            diff = narrow - prev_count[i];
            tick_total[i] = tick_total[i] + {{16{diff[15]}}, diff};
            prev_count[i] = narrow;
          end
          if (alive) begin
            t32 = model_target[i];
            mag = (t32 < 0) ? -t32 : t32;
            scaled = mag * 32'(DUTY_MAX) / 32'(SPEED_FULL);
            if (scaled > 32'(DUTY_MAX)) scaled = 32'(DUTY_MAX);
            held_duty[i] = scaled[12:0];
            if (scaled == 0) held_dir[i] = DIR_OFF;
            else if (t32 > 0) held_dir[i] = DIR_FORWARD;
            else held_dir[i] = DIR_REVERSE;
          end else begin
            held_duty[i] = '0;
            held_dir[i]  = DIR_OFF;
          end
        end
      end

      for (int i = 0; i < NUM_WHEELS; i++) begin
        r.motor_index = 2'(i);
        r.dir         = held_dir[i];
        r.duty        = held_duty[i];
        r.ticks       = tick_total[i];
        r.report      = control;
        r.last_motor  = (2'(i) == LAST_WHEEL);
        wheel_reports_due.push_back(r);
      end
    end
  endtask

  // Offer one item at a falling edge, hold it until the core takes it, then
  // predict. Leave valid high so back-to-back items need no second assignment.
  task automatic send_step(input step_t s);
    begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
        step_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      step_ch.valid             <= 1'b1;
      step_ch.cmd               <= s.cmd;
      step_ch.now_ms            <= s.now_ms;
      step_ch.rpm_front_left    <= s.rpm[0];
      step_ch.rpm_front_right   <= s.rpm[1];
      step_ch.rpm_rear_left     <= s.rpm[2];
      step_ch.rpm_rear_right    <= s.rpm[3];
      step_ch.count_front_left  <= s.count[0];
      step_ch.count_front_right <= s.count[1];
      step_ch.count_rear_left   <= s.count[2];
      step_ch.count_rear_right  <= s.count[3];
      @(posedge clk);
      while (!step_ch.ready) @(posedge clk);
      drive_model_step(s);
    end
  endtask

  // Drop valid, wait for every owed report, then let the pipeline settle.
  task automatic drain;
    begin
      @(negedge clk);
      step_ch.valid <= 1'b0;
      while (wheel_reports_due.size() != 0) @(negedge clk);
      repeat (HOLD_OFF) @(negedge clk);
    end
  endtask

  // Write one register; only called while the core is idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(negedge clk);
      cfg_we <= 1'b0;
      case (idx)
        CFG_HB_TIMEOUT:    hb_timeout_cfg = val;
        CFG_CTRL_INTERVAL: interval_cfg   = val;
        CFG_WIDE_MASK:     wide_mask_cfg  = val[3:0];
        default: ;
      endcase
    end
  endtask

  function automatic rpm_arr_t rpm4(input logic signed [15:0] fl, fr, rl, rr);
    rpm_arr_t r;
    r[0] = fl;
    r[1] = fr;
    r[2] = rl;
    r[3] = rr;
    return r;
  endfunction

  function automatic count_arr_t counts4(input logic [31:0] fl, fr, rl, rr);
    count_arr_t c;
    c[0] = fl;
    c[1] = fr;
    c[2] = rl;
    c[3] = rr;
    return c;
  endfunction

  // Mostly moderate speeds; now and then any 16-bit value.
  function automatic logic signed [15:0] rand_rpm();
    logic [31:0] raw;
    int          v;
    raw = $urandom();
    if (raw[31:29] == 3'b000) return raw[15:0];
    v = int'($urandom_range(0, 800)) - 400;
    return v[15:0];
  endfunction

  // Advance the millisecond clock and send a pass with explicit counter samples.
  task automatic pass_raw(input logic [1:0] c, input logic [31:0] dt, input rpm_arr_t rpm,
                          input count_arr_t cnt);
    step_t s;
    begin
      clock_ms = clock_ms + dt;
      s.cmd    = c;
      s.now_ms = clock_ms;
      s.rpm    = rpm;
      s.count  = cnt;
      enc_count = cnt;
      send_step(s);
    end
  endtask

  // Send a pass whose encoders moved by a plausible amount, or jumped anywhere.
  task automatic pass_loop(input logic [1:0] c, input logic [31:0] dt, input rpm_arr_t rpm);
    count_arr_t  cnt;
    logic [31:0] jump;
    int          delta;
    begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        jump = $urandom();
        if (jump[31:28] == 4'd0) begin
          cnt[i] = $urandom();
        end else begin
          delta = int'($urandom_range(0, 6000)) - 3000;
          cnt[i] = enc_count[i] + delta;
        end
      end
      pass_raw(c, dt, rpm, cnt);
    end
  endtask

  // Duty scaling and direction at the speed extremes, with every pass a
  // control step and a watchdog that never runs out.
  task automatic test_drive_scaling;
    begin
      cfg_write(CFG_CTRL_INTERVAL, 16'd0);
      cfg_write(CFG_HB_TIMEOUT, 16'hFFFF);
      pass_loop(CMD_HEARTBEAT, 32'd1, rpm4(0, 0, 0, 0));
      pass_loop(CMD_VELOCITY, 32'd1, rpm4(0, 1, -1, 18));
      pass_loop(CMD_VELOCITY, 32'd1, rpm4(299, 300, 301, -300));
      pass_loop(CMD_VELOCITY, 32'd1, rpm4(32767, -32768, 17, -17));
      pass_loop(CMD_VELOCITY, 32'd1, rpm4(-1, -299, 5000, -5000));
      // Other frames leave the targets alone even with speeds on the bus.
      pass_loop(CMD_OTHER, 32'd1, rpm4(100, 100, 100, 100));
      // Same millisecond again: still a control step with a zero interval.
      pass_loop(CMD_NONE, 32'd0, rpm4(-7, 7, -7, 7));
      drain;
    end
  endtask

  // Watchdog edge at exactly the timeout, expiry with and without a control
  // step, a heartbeat that revives, and a zero timeout.
  task automatic test_watchdog;
    begin
      cfg_write(CFG_HB_TIMEOUT, 16'd10);
      cfg_write(CFG_CTRL_INTERVAL, 16'd5);
      pass_loop(CMD_HEARTBEAT, 32'd5, rpm4(0, 0, 0, 0));
      pass_loop(CMD_VELOCITY, 32'd5, rpm4(150, -150, 300, -1));
      pass_loop(CMD_NONE, 32'd5, rpm4(0, 0, 0, 0));
      // One past the timeout, between control steps: drives drop at once.
      pass_loop(CMD_NONE, 32'd1, rpm4(0, 0, 0, 0));
      // A velocity frame into a dead watchdog is wiped on the same pass.
      pass_loop(CMD_VELOCITY, 32'd4, rpm4(200, 200, -200, -200));
      // Heartbeat long after expiry: taken first, so this pass is alive.
      pass_loop(CMD_HEARTBEAT, 32'd50, rpm4(0, 0, 0, 0));
      pass_loop(CMD_VELOCITY, 32'd1, rpm4(-250, 250, 1, -32768));
      pass_loop(CMD_NONE, 32'd5, rpm4(0, 0, 0, 0));
      drain;
      cfg_write(CFG_HB_TIMEOUT, 16'd0);
      pass_loop(CMD_HEARTBEAT, 32'd7, rpm4(0, 0, 0, 0));
      pass_loop(CMD_VELOCITY, 32'd0, rpm4(120, -120, 60, -60));
      pass_loop(CMD_NONE, 32'd5, rpm4(0, 0, 0, 0));
      drain;
    end
  endtask

  // Narrow counter unwrap across the 16-bit boundary, wide counters, a mask
  // change at run time, the longest interval, and the millisecond wrap.
  task automatic test_encoder_extension;
    begin
      cfg_write(CFG_HB_TIMEOUT, 16'hFFFF);
      cfg_write(CFG_CTRL_INTERVAL, 16'd1);
      cfg_write(CFG_WIDE_MASK, 16'h0);
      cfg_write(CFG_UNUSED, 16'hFFFF);
      pass_raw(CMD_HEARTBEAT, 32'd1, rpm4(0, 0, 0, 0),
               counts4(32'h0000_FFFF, 32'h0000_8000, 32'hFFFF_7FFF, 32'h1234_0000));
      pass_raw(CMD_VELOCITY, 32'd1, rpm4(90, -90, 45, -45),
               counts4(32'h0001_0001, 32'h0000_0000, 32'h0000_FFFF, 32'hABCD_0001));
      drain;
      cfg_write(CFG_WIDE_MASK, 16'hF);
      pass_raw(CMD_NONE, 32'd1, rpm4(0, 0, 0, 0),
               counts4(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
      drain;
      cfg_write(CFG_WIDE_MASK, 16'h5);
      pass_raw(CMD_NONE, 32'd1, rpm4(0, 0, 0, 0),
               counts4(32'h5555_AAAA, 32'h0000_0010, 32'hAAAA_5555, 32'h0000_FFF0));
      drain;
      cfg_write(CFG_CTRL_INTERVAL, 16'hFFFF);
      pass_loop(CMD_NONE, 32'd65534, rpm4(0, 0, 0, 0));
      pass_loop(CMD_NONE, 32'd1, rpm4(0, 0, 0, 0));
      // Step the clock back 16 ms: the modulo difference is huge, so control.
      pass_loop(CMD_HEARTBEAT, 32'hFFFF_FFF0, rpm4(0, 0, 0, 0));
      drain;
    end
  endtask

  // Random batches, each under a fresh register setting. Most passes follow a
  // normal loop (small time steps, heartbeats, speed updates); the rest jump
  // the clock anywhere or carry ignored frames. Bursts stop near the end.
  task automatic test_random_traffic(input int n_items);
    int          sent;
    int          len;
    int          roll;
    logic [1:0]  c;
    logic [15:0] hb_val;
    logic [15:0] iv_val;
    begin
      sent = 0;
      while (sent < n_items) begin
        drain;
        case ($urandom_range(0, 4))
          0:       hb_val = 16'd0;
          1:       hb_val = 16'hFFFF;
          2:       hb_val = HB_TIMEOUT_RST;
          default: hb_val = 16'($urandom_range(5, 120));
        endcase
        case ($urandom_range(0, 5))
          0:       iv_val = 16'd0;
          1:       iv_val = 16'hFFFF;
          2:       iv_val = 16'd1;
          default: iv_val = 16'($urandom_range(2, 30));
        endcase
        cfg_write(CFG_HB_TIMEOUT, hb_val);
        cfg_write(CFG_CTRL_INTERVAL, iv_val);
        cfg_write(CFG_WIDE_MASK, 16'($urandom_range(0, 15)));
        bursts_on = (sent < n_items - 25) && ($urandom_range(0, 3) != 0);
        len = $urandom_range(8, 20);
        for (int k = 0; k < len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 10) begin
            // Jump the clock anywhere, any frame.
            c = 2'($urandom_range(0, 3));
            pass_loop(c, $urandom(), rpm4(rand_rpm(), rand_rpm(), rand_rpm(), rand_rpm()));
          end else if (roll < 20) begin
            c = ($urandom_range(0, 1) == 0) ? CMD_OTHER : CMD_NONE;
            pass_loop(c, 32'($urandom_range(0, 40)),
                      rpm4(rand_rpm(), rand_rpm(), rand_rpm(), rand_rpm()));
          end else begin
            roll = $urandom_range(0, 9);
            if (roll < 3) c = CMD_HEARTBEAT;
            else if (roll < 6) c = CMD_VELOCITY;
            else c = CMD_NONE;
            pass_loop(c, 32'($urandom_range(0, 40)),
                      rpm4(rand_rpm(), rand_rpm(), rand_rpm(), rand_rpm()));
          end
        end
        sent += len;
      end
      bursts_on = 1'b0;
      drain;
    end
  endtask

  // Receiver: hold ready low in random bursts while bursts are on.
  initial begin : result_pacer
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted report with the oldest one owed.
  always @(posedge clk) begin : report_check
    wheel_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (wheel_reports_due.size() == 0) begin
        flag_error($sformatf("report for wheel %0d with none owed", result_ch.motor_index));
      end else begin
        want = wheel_reports_due.pop_front();
        if (result_ch.motor_index !== want.motor_index)
          flag_error($sformatf("motor_index: got %0d, want %0d",
                               result_ch.motor_index, want.motor_index));
        if (result_ch.drive_dir !== want.dir)
          flag_error($sformatf("wheel %0d drive_dir: got %0d, want %0d",
                               want.motor_index, result_ch.drive_dir, want.dir));
        if (result_ch.duty !== want.duty)
          flag_error($sformatf("wheel %0d duty: got %0d, want %0d",
                               want.motor_index, result_ch.duty, want.duty));
        if (result_ch.cumulative_ticks !== want.ticks)
          flag_error($sformatf("wheel %0d cumulative_ticks: got %h, want %h",
                               want.motor_index, result_ch.cumulative_ticks, want.ticks));
        if (result_ch.report !== want.report)
          flag_error($sformatf("wheel %0d report: got %b, want %b",
                               want.motor_index, result_ch.report, want.report));
        if (result_ch.last_motor !== want.last_motor)
          flag_error($sformatf("wheel %0d last_motor: got %b, want %b",
                               want.motor_index, result_ch.last_motor, want.last_motor));
      end
    end
  end

  // Count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (rst || cfg_we || (step_ch.valid && step_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hung run: report it and stop.
  initial begin : hang_guard
    wait (stall_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_sequence
    // Drive every input to a known value and hold reset, then release it.
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_HB_TIMEOUT;
    cfg_data                  = '0;
    step_ch.valid             = 1'b0;
    step_ch.cmd               = CMD_NONE;
    step_ch.now_ms            = '0;
    step_ch.rpm_front_left    = '0;
    step_ch.rpm_front_right   = '0;
    step_ch.rpm_rear_left     = '0;
    step_ch.rpm_rear_right    = '0;
    step_ch.count_front_left  = '0;
    step_ch.count_front_right = '0;
    step_ch.count_rear_left   = '0;
    step_ch.count_rear_right  = '0;
    reset_model();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    bursts_on = 1'b1;
    test_drive_scaling();
    test_watchdog();
    test_encoder_extension();
    test_random_traffic(120);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
